@@ design/albr_pkg.sv @@
// Shared types, constants and helpers for the ambient light brightness ramp.
package albr_pkg;

	localparam int LEVELS_DEF = 4;
	localparam int THRESH_N   = 4;
	localparam int TABLE_N    = 4;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = SAMPLE_W + 2;
	localparam int BRIGHT_W   = 8;
	localparam int LVL_W      = 3;
	localparam int SEL_W      = 2;
	localparam int OFFSET_W   = 3;
	localparam int RING_N     = 3;
	localparam int SLOT_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int RAMP_FAR   = 10;
	localparam int RAMP_EXTRA = 3;
	localparam int RAMP_STEP  = 1;

	localparam logic [SAMPLE_W-1:0] RING_RESET    = SAMPLE_W'(128);
	localparam logic [BRIGHT_W-1:0] TARGET_RESET  = BRIGHT_W'(255);
	localparam logic [BRIGHT_W-1:0] CURRENT_RESET = BRIGHT_W'(70);
	localparam logic [THRESH_N-1:0][SAMPLE_W-1:0] THRESH_RESET = {
		16'd30000, 16'd12000, 16'd4000, 16'd1000
	};
	localparam logic [CFG_DATA_W-1:0] TABLE_RESET = 32'hFFA0_6020;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESH_0 = 3'd0,
		REG_THRESH_1 = 3'd1,
		REG_THRESH_2 = 3'd2,
		REG_THRESH_3 = 3'd3,
		REG_TABLE    = 3'd4,
		REG_OFFSET   = 3'd5
	} cfg_reg_t;

	// Thresholds are kept as three times the written value, so the level
	// compare can run on the ring sum instead of the truncated average.
	typedef struct packed {
		logic [THRESH_N-1:0][SUM_W-1:0]   thresh3;
		logic [TABLE_N-1:0][BRIGHT_W-1:0] bright_table;
		logic signed [OFFSET_W-1:0]       offset;
	} albr_cfg_t;

	function automatic logic [SUM_W-1:0] times3(input logic [SAMPLE_W-1:0] v);
		logic [SUM_W-1:0] w;
		w = SUM_W'(v);
		return (w << 1) + w;
	endfunction

	localparam albr_cfg_t CFG_RESET = '{
		thresh3:      {times3(THRESH_RESET[3]), times3(THRESH_RESET[2]),
		               times3(THRESH_RESET[1]), times3(THRESH_RESET[0])},
		bright_table: TABLE_RESET,
		offset:       '0
	};

endpackage

@@ design/albr_level.sv @@
// Light level search, offset clamp and target brightness lookup.
module albr_level import albr_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  albr_cfg_t          cfg,
	input  logic [SUM_W-1:0]   ring_sum,
	output logic [BRIGHT_W-1:0] target,
	output logic               night
);

	logic [LVL_W-1:0]        lvl;
	logic signed [LVL_W:0]   shifted;
	logic [SEL_W-1:0]        sel;

	// Average below threshold is the same as sum below three times threshold.
	always_comb begin
		lvl = LVL_W'(LEVELS);
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (ring_sum < cfg.thresh3[i]) begin
				lvl = LVL_W'(i);
			end
		end
	end

	assign night   = (lvl == '0);
	assign shifted = $signed({1'b0, lvl}) + $signed({cfg.offset[OFFSET_W-1], cfg.offset});

	always_comb begin
		priority if (shifted < 0) begin
			sel = '0;
		end else if (shifted > $signed((LVL_W+1)'(LEVELS - 1))) begin
			sel = SEL_W'(LEVELS - 1);
		end else begin
			sel = shifted[SEL_W-1:0];
		end
	end

	assign target = cfg.bright_table[sel];

endmodule

@@ design/ambient_light_brightness_ramp_core.sv @@
// Top level of the ambient light brightness ramp.
// An accepted transaction passes through the input register and then the state and result registers.
// Throughput: one transaction per cycle while the result is not stalled; the ring update, level search and ramp
// step all settle between the input register and the state and result registers.
// Reset: configuration, valid and state registers return to their defaults, the ring holds 128 in every slot,
// target brightness is 255, current brightness is 70 and night mode is off.
module ambient_light_brightness_ramp_core import albr_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  sample_valid,
	input  logic [SAMPLE_W-1:0]   light_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  changed,
	output logic [BRIGHT_W-1:0]   brightness_out,
	output logic [BRIGHT_W-1:0]   target_out,
	output logic                  night_mode
);

	albr_cfg_t                  cfg_q;

	logic                       valid_s1;
	logic                       sample_valid_s1;
	logic [SAMPLE_W-1:0]        light_sample_s1;

	logic [RING_N-1:0][SAMPLE_W-1:0] ring_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [BRIGHT_W-1:0]        target_q;
	logic [BRIGHT_W-1:0]        current_q;
	logic                       night_q;
	logic                       changed_q;
	logic                       out_valid_q;

	logic                       advance;
	logic [RING_N-1:0][SAMPLE_W-1:0] ring_next;
	logic [SUM_W-1:0]           ring_sum;
	logic [BRIGHT_W-1:0]        lvl_target;
	logic                       lvl_night;
	logic [BRIGHT_W-1:0]        target_next;
	logic                       night_next;
	logic                       up;
	logic [BRIGHT_W-1:0]        diff;
	logic [BRIGHT_W-1:0]        step;
	logic                       changed_next;
	logic [BRIGHT_W-1:0]        current_next;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESH_0: cfg_q.thresh3[0] <= times3(wr_data[SAMPLE_W-1:0]);
				REG_THRESH_1: cfg_q.thresh3[1] <= times3(wr_data[SAMPLE_W-1:0]);
				REG_THRESH_2: cfg_q.thresh3[2] <= times3(wr_data[SAMPLE_W-1:0]);
				REG_THRESH_3: cfg_q.thresh3[3] <= times3(wr_data[SAMPLE_W-1:0]);
				REG_TABLE:    cfg_q.bright_table <= wr_data;
				REG_OFFSET:   cfg_q.offset <= wr_data[OFFSET_W-1:0];
				default:      ;
			endcase
		end
	end

	// The stage-one item moves on whenever the result register is free or being taken.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_valid_s1 <= sample_valid;
			light_sample_s1 <= light_sample;
		end
	end

	// Ring with the new sample written into its slot.
	always_comb begin
		for (int i = 0; i < RING_N; i++) begin
			if (sample_valid_s1 && slot_q == SLOT_W'(i)) begin
				ring_next[i] = light_sample_s1;
			end else begin
				ring_next[i] = ring_q[i];
			end
		end
	end

	assign ring_sum = SUM_W'(ring_next[0]) + SUM_W'(ring_next[1]) + SUM_W'(ring_next[2]);

	albr_level #(
		.LEVELS (LEVELS)
	) u_level (
		.cfg      (cfg_q),
		.ring_sum (ring_sum),
		.target   (lvl_target),
		.night    (lvl_night)
	);

	assign target_next = sample_valid_s1 ? lvl_target : target_q;
	assign night_next  = sample_valid_s1 ? lvl_night : night_q;

	// Ramp: one step, or four when the gap after a single step is still large.
	assign up           = target_next > current_q;
	assign diff         = up ? (target_next - current_q) : (current_q - target_next);
	assign step         = (diff > BRIGHT_W'(RAMP_FAR + RAMP_STEP)) ?
	                      BRIGHT_W'(RAMP_STEP + RAMP_EXTRA) : BRIGHT_W'(RAMP_STEP);
	assign changed_next = target_next != current_q;

	always_comb begin
		if (!changed_next) begin
			current_next = current_q;
		end else if (up) begin
			current_next = current_q + step;
		end else begin
			current_next = current_q - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q    <= {RING_N{RING_RESET}};
			slot_q    <= '0;
			target_q  <= TARGET_RESET;
			current_q <= CURRENT_RESET;
			night_q   <= 1'b0;
		end else if (advance) begin
			ring_q    <= ring_next;
			target_q  <= target_next;
			current_q <= current_next;
			night_q   <= night_next;
			if (sample_valid_s1) begin
				slot_q <= (slot_q == SLOT_W'(RING_N - 1)) ? '0 : slot_q + SLOT_W'(1);
			end
		end
	end

	// The state registers double as the result payload; they only move on advance,
	// which never happens while a result is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			changed_q <= changed_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign changed        = changed_q;
	assign brightness_out = current_q;
	assign target_out     = target_q;
	assign night_mode     = night_q;

endmodule

@@ design/albr_checker.sv @@
// Port-level checker for the brightness ramp core, with its bind.
module albr_checker import albr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic                changed,
	input logic [BRIGHT_W-1:0] brightness_out,
	input logic [BRIGHT_W-1:0] target_out,
	input logic                night_mode
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(changed) && $stable(brightness_out)
			&& $stable(target_out) && $stable(night_mode))
		else $error("stalled result payload changed");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no result pending");

	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !changed |-> brightness_out == target_out)
		else $error("brightness differs from target on an unchanged result");

endmodule

bind ambient_light_brightness_ramp_core albr_checker u_albr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.changed        (changed),
	.brightness_out (brightness_out),
	.target_out     (target_out),
	.night_mode     (night_mode)
);

@@ test/ambient_light_brightness_ramp_core_tb.sv @@
// Self-checking testbench for the ambient light brightness ramp core.
module ambient_light_brightness_ramp_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import albr_pkg::*;

	localparam int NLEV          = LEVELS_DEF;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 135;
	localparam int REPORT_MAX    = 40;

	// Indexes past the last register; writes to them must leave the state alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int STALL_NONE   = 0;
	localparam int STALL_RANDOM = 1;
	localparam int STALL_BURST  = 2;

	typedef struct packed {
		logic                chg;
		logic [BRIGHT_W-1:0] bright;
		logic [BRIGHT_W-1:0] tgt;
		logic                night;
	} ramp_result_t;

	class ramp_scoreboard;
		logic [SAMPLE_W-1:0]        thr [THRESH_N];
		logic [CFG_DATA_W-1:0]      bright_tbl;
		logic signed [OFFSET_W-1:0] offs;
		logic [SAMPLE_W-1:0]        ring [RING_N];
		int                         slot;
		logic [BRIGHT_W-1:0]        tgt;
		logic [BRIGHT_W-1:0]        now_lvl;
		logic                       night;
		ramp_result_t               pending_results [$];
		int                         errors;

		function new();
			for (int i = 0; i < THRESH_N; i++)
				thr[i] = THRESH_RESET[i];
			for (int i = 0; i < RING_N; i++)
				ring[i] = RING_RESET;
			bright_tbl = TABLE_RESET;
			offs       = '0;
			slot       = 0;
			tgt        = TARGET_RESET;
			now_lvl    = CURRENT_RESET;
			night      = 1'b0;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THRESH_0: thr[0] = data[SAMPLE_W-1:0];
				REG_THRESH_1: thr[1] = data[SAMPLE_W-1:0];
				REG_THRESH_2: thr[2] = data[SAMPLE_W-1:0];
				REG_THRESH_3: thr[3] = data[SAMPLE_W-1:0];
				REG_TABLE:    bright_tbl = data;
				REG_OFFSET:   offs = data[OFFSET_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted update transaction.
		function void note_update(logic new_smp, logic [SAMPLE_W-1:0] smp);
			int unsigned  avg;
			int           lvl;
			ramp_result_t r;
			if (new_smp) begin
				ring[slot] = smp;
				slot = (slot + 1) % RING_N;
				avg = (32'(ring[0]) + 32'(ring[1]) + 32'(ring[2])) / 3;
				lvl = 0;
				while (lvl < NLEV && avg >= thr[lvl])
					lvl++;
				night = (lvl == 0);
				lvl = lvl + offs;
				if (lvl < 0)
					lvl = 0;
				if (lvl > NLEV - 1)
					lvl = NLEV - 1;
				tgt = bright_tbl[8*lvl +: 8];
			end
			r.chg = (tgt != now_lvl);
			if (tgt > now_lvl) begin
				now_lvl += BRIGHT_W'(RAMP_STEP);
				if (tgt - now_lvl > RAMP_FAR)
					now_lvl += BRIGHT_W'(RAMP_EXTRA);
			end else if (tgt < now_lvl) begin
				now_lvl -= BRIGHT_W'(RAMP_STEP);
				if (now_lvl - tgt > RAMP_FAR)
					now_lvl -= BRIGHT_W'(RAMP_EXTRA);
			end
			r.bright = now_lvl;
			r.tgt    = tgt;
			r.night  = night;
			pending_results.push_back(r);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report(string msg);
			if (errors < REPORT_MAX)
				$display("mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_update(ramp_result_t got);
			ramp_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result, brightness %0d", got.bright));
				return;
			end
			want = pending_results.pop_front();
			if (got.chg !== want.chg)
				report($sformatf("changed %b, expected %b", got.chg, want.chg));
			if (got.bright !== want.bright)
				report($sformatf("brightness %0d, expected %0d", got.bright, want.bright));
			if (got.tgt !== want.tgt)
				report($sformatf("target %0d, expected %0d", got.tgt, want.tgt));
			if (got.night !== want.night)
				report($sformatf("night mode %b, expected %b", got.night, want.night));
		endtask
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  wr_en        = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index     = '0;
	logic [CFG_DATA_W-1:0] wr_data      = '0;
	logic                  in_valid     = 1'b0;
	logic                  sample_valid = 1'b0;
	logic [SAMPLE_W-1:0]   light_sample = '0;
	logic                  out_stall    = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  changed;
	logic [BRIGHT_W-1:0]   brightness_out;
	logic [BRIGHT_W-1:0]   target_out;
	logic                  night_mode;

	ramp_scoreboard sb = new();

	cfg_reg_t thr_regs [THRESH_N] = '{REG_THRESH_0, REG_THRESH_1, REG_THRESH_2, REG_THRESH_3};

	int idle_cycles = 0;
	int stall_mode  = STALL_NONE;
	int mode_left   = 0;
	int stall_left  = 0;
	int burst_left  = 0;
	int gap_max     = 6;

	always #6 clk = ~clk;

	ambient_light_brightness_ramp_core #(
		.LEVELS(NLEV)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_valid(sample_valid),
		.light_sample(light_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.changed(changed),
		.brightness_out(brightness_out),
		.target_out(target_out),
		.night_mode(night_mode)
	);

	// Transaction monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_update(sample_valid, light_sample);
			if (out_valid && !out_stall)
				sb.check_update(ramp_result_t'{changed, brightness_out, target_out, night_mode});
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// The receiver switches between no stalls, scattered stalls and long stall runs.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_BURST);
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
			STALL_BURST: begin
				if (stall_left == 0 && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 12);
				out_stall <= (stall_left != 0);
				if (stall_left != 0)
					stall_left--;
			end
			default: out_stall <= 1'b0;
		endcase
	end

	task send_update(logic sv, logic [SAMPLE_W-1:0] smp);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     <= 1'b1;
		sample_valid <= sv;
		light_sample <= smp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Holds the sender until every expected result is back and the pipeline is empty.
	task let_results_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task random_config();
		int                  choice;
		int                  base;
		logic [SAMPLE_W-1:0] t;
		choice = $urandom_range(0, 3);
		base   = 0;
		for (int i = 0; i < THRESH_N; i++) begin
			case (choice)
				0: begin
					base += $urandom_range(0, 20000);
					if (base > 65535)
						base = 65535;
					t = SAMPLE_W'(base);
				end
				1: t = SAMPLE_W'($urandom);
				2: t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				default: t = SAMPLE_W'($urandom_range(0, 600));
			endcase
			cfg_write(thr_regs[i], {16'($urandom), t});
		end
		case ($urandom_range(0, 3))
			0: cfg_write(REG_TABLE, 32'hFFFF_FFFF);
			1: cfg_write(REG_TABLE, 32'h0000_0000);
			default: cfg_write(REG_TABLE, $urandom);
		endcase
		cfg_write(REG_OFFSET, $urandom);
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
		wr_en <= 1'b0;
	endtask

	initial begin
		int                  focus;
		int                  v;
		int                  focus_left;
		logic [SAMPLE_W-1:0] smp;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: ramp alone, night, top level, ignored sample, boundary.
		send_update(1'b0, 16'h0000);
		send_update(1'b0, 16'h0000);
		repeat (3) send_update(1'b1, 16'h0000);
		repeat (3) send_update(1'b1, 16'hFFFF);
		send_update(1'b0, 16'hFFFF);
		send_update(1'b1, 16'h5555);
		send_update(1'b1, 16'hAAAA);
		repeat (3) send_update(1'b1, 16'd1000);

		// Thresholds out of order, offset pattern 100, writes to unused indexes.
		let_results_drain();
		cfg_write(REG_THRESH_0, 32'hFFFF_0000);
		cfg_write(REG_THRESH_1, 32'h0000_FFFF);
		cfg_write(REG_THRESH_2, 32'h0000_000A);
		cfg_write(REG_THRESH_3, 32'h0000_9C40);
		cfg_write(REG_TABLE, 32'h01FF_8000);
		cfg_write(REG_OFFSET, 32'hFFFF_FFFC);
		cfg_write(REG_SPARE_6, 32'h0000_0000);
		cfg_write(REG_SPARE_7, 32'hFFFF_FFFF);
		wr_en <= 1'b0;
		send_update(1'b1, 16'h1234);
		send_update(1'b1, 16'h0000);
		send_update(1'b0, 16'h0000);

		// All thresholds at zero with the largest positive offset.
		let_results_drain();
		for (int i = 0; i < THRESH_N; i++)
			cfg_write(thr_regs[i], 32'h0000_0000);
		cfg_write(REG_TABLE, 32'hFFFF_FFFF);
		cfg_write(REG_OFFSET, 32'h0000_0003);
		wr_en <= 1'b0;
		send_update(1'b1, 16'h0000);
		send_update(1'b1, 16'hFFFF);

		// All thresholds at full scale, so even the brightest average stays below none.
		let_results_drain();
		for (int i = 0; i < THRESH_N; i++)
			cfg_write(thr_regs[i], 32'h0000_FFFF);
		cfg_write(REG_TABLE, 32'h0000_0000);
		wr_en <= 1'b0;
		send_update(1'b1, 16'hFFFF);
		send_update(1'b1, 16'h0000);
		send_update(1'b1, 16'h8000);

		// Random part: samples mostly cluster around a moving focus, often a threshold,
		// so the average crosses levels and the ramp gets long runs toward one target.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			let_results_drain();
			random_config();
			gap_max    = (p % 3 == 0) ? 0 : $urandom_range(2, 12);
			focus_left = 0;
			focus      = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (focus_left == 0) begin
					focus_left = $urandom_range(8, 30);
					case ($urandom_range(0, 4))
						0: focus = $urandom_range(0, 65535);
						1: focus = $urandom_range(0, 1) ? 65535 : 0;
						default: focus = sb.thr[$urandom_range(0, THRESH_N - 1)];
					endcase
				end
				focus_left--;
				case ($urandom_range(0, 9))
					6, 7: smp = SAMPLE_W'($urandom);
					8: smp = 16'h0000;
					9: smp = 16'hFFFF;
					default: begin
						v = focus + int'($urandom_range(0, 8)) - 4;
						if (v < 0)
							v = 0;
						if (v > 65535)
							v = 65535;
						smp = SAMPLE_W'(v);
					end
				endcase
				send_update($urandom_range(0, 3) != 0, smp);
				if ($urandom_range(0, 199) == 0)
					let_results_drain();
			end
		end

		let_results_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
